>>> design/tgfa_pkg.sv
// Shared types and constants for the worker-grid split adjuster.
// Holds the beat structs, register indexes and the divider interface.
// No dependencies.
package tgfa_pkg;

  localparam int MAX_WORKERS = 256;
  localparam int DIM_BITS    = 24;

  // Width of a worker or way count field; also holds one above MAX_WORKERS.
  localparam int WAY_W   = 9;
  localparam int RPAN_W  = 7;
  localparam int CPAN_W  = 9;
  localparam int CFG_W   = 9;
  // Dividend width: a dimension plus a divisor minus one for rounding up.
  localparam int DIV_W   = DIM_BITS + 1;
  localparam int SUM_W   = DIM_BITS + 1;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [RPAN_W-1:0] ROW_PANEL_RST = RPAN_W'(6);
  localparam logic [CPAN_W-1:0] COL_PANEL_RST = CPAN_W'(64);
  localparam logic              PANEL_EN_RST  = 1'b1;

  typedef enum logic [1:0] {
    CFG_ROW_PANEL = 2'd0,
    CFG_COL_PANEL = 2'd1,
    CFG_PANEL_EN  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] rows;
    logic [DIM_BITS-1:0] cols;
    logic [WAY_W-1:0]    workers;
    logic [WAY_W-1:0]    row_ways_in;
    logic [WAY_W-1:0]    col_ways_in;
  } in_item_t;

  typedef struct packed {
    logic [WAY_W-1:0] row_ways_out;
    logic [WAY_W-1:0] col_ways_out;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic             short_op;
    logic [DIV_W-1:0] dividend;
    logic [WAY_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [WAY_W-1:0] rem;
  } div_rsp_t;

  // Zero counts become one, counts past the limit saturate.
  function automatic logic [WAY_W-1:0] clamp_count(input logic [WAY_W-1:0] v);
    logic [WAY_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = WAY_W'(1);
    end else if (v > WAY_W'(MAX_WORKERS)) begin
      r = WAY_W'(MAX_WORKERS);
    end
    return r;
  endfunction

endpackage

>>> design/thread_grid_factor_adjust_unit.sv
// Top level of the worker-grid split adjuster: sequencer, config registers
// and output register. Depends on tgfa_pkg and tgfa_serial_div.
//
// The block takes one beat holding a matrix size, a worker count and a
// starting row-by-column split of the workers, and returns one beat with the
// adjusted split. It works on one item at a time; in_ready is high while the
// sequencer is idle, and a finished result waits in the output register so a
// new item can be accepted before it is taken. All divisions go through
// one shared bit-serial divider, so the latency is set by how many divisions
// an item needs, a division of a dimension taking longer than the trial of
// each divisor candidate while searching for the next or previous divisor
// of the worker count. Stage one uses four to six dimension divisions and
// four divisor searches; stage two adds up to thirteen dimension divisions
// and six searches. A worker count with few divisors (a prime near 256)
// can make a single search try nearly every candidate count.
// Configuration writes are taken on every cycle (cfg_ready is always high)
// and must only be issued while the block holds no item.
module thread_grid_factor_adjust_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tgfa_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tgfa_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [tgfa_pkg::CFG_W-1:0]         cfg_data
);

  localparam int WW = tgfa_pkg::WAY_W;
  localparam int DB = tgfa_pkg::DIM_BITS;
  localparam int DW = tgfa_pkg::DIV_W;
  localparam int SW = tgfa_pkg::SUM_W;

  typedef enum logic [4:0] {
    S_IDLE, S_CUR_A, S_CUR_B, S_SRCH_INIT, S_SRCH_DIV,
    S_NRI, S_PRI, S_NCJ, S_PCJ,
    S_WR_A, S_WR_B, S_WC_A, S_WC_B,
    S_MU, S_NU, S_MOD, S_BEST_A, S_BEST_B,
    S_STEP, S_CR, S_CC, S_WK_A, S_WK_B, S_DONE
  } state_t;

  // Configuration registers.
  logic [tgfa_pkg::RPAN_W-1:0] row_panel_r;
  logic [tgfa_pkg::CPAN_W-1:0] col_panel_r;
  logic                        panel_en_r;

  // Sequencer state and working registers.
  state_t              state_r;
  state_t              srch_ret_r;
  logic                wait_r;
  logic [DB-1:0]       m_r;
  logic [DB-1:0]       n_r;
  logic [WW-1:0]       nt_r;
  logic [WW-1:0]       ri_r;
  logic [WW-1:0]       cj_r;
  logic [WW-1:0]       nri_r;
  logic [WW-1:0]       pri_r;
  logic [WW-1:0]       ncj_r;
  logic [WW-1:0]       pcj_r;
  logic [WW-1:0]       tri_r;
  logic [WW-1:0]       tcj_r;
  logic [WW-1:0]       cand_r_r;
  logic [WW-1:0]       cand_c_r;
  logic [WW-1:0]       srch_cur_r;
  logic [WW-1:0]       srch_t_r;
  logic [WW-1:0]       srch_res_r;
  logic                srch_up_r;
  logic [DB-1:0]       mu_r;
  logic [DB-1:0]       nu_r;
  logic [SW-1:0]       acc_r;
  logic [SW-1:0]       cur_r;
  logic [SW-1:0]       best_r;
  logic [1:0]          step_r;
  logic                out_valid_r;
  tgfa_pkg::out_item_t out_data_r;

  // Divider hookup.
  tgfa_pkg::div_req_t  div_req;
  tgfa_pkg::div_rsp_t  div_rsp;
  logic [DB-1:0]       op_base;
  logic [WW-1:0]       op_divisor;
  logic                op_ceil;
  logic                op_short;
  logic                div_state;
  logic                srch_term;
  logic [DW-1:0]       ceil_add;
  logic [SW-1:0]       sum;
  logic [WW-1:0]       row_panel_eff;
  logic [WW-1:0]       col_panel_eff;
  logic                orient_ok;
  logic                done_go;

  assign row_panel_eff = (row_panel_r == '0) ? WW'(1) : WW'(row_panel_r);
  assign col_panel_eff = (col_panel_r == '0) ? WW'(1) : WW'(col_panel_r);

  // An upward search ends once the candidate passes the worker count; a
  // downward one ends at one, which divides everything.
  assign srch_term = srch_up_r ? (srch_t_r > nt_r) : (srch_t_r == WW'(1));

  // Operand selection for the state that owns the divider.
  always_comb begin
    op_base    = m_r;
    op_divisor = ri_r;
    op_ceil    = 1'b0;
    op_short   = 1'b0;
    div_state  = 1'b1;
    case (state_r)
      S_CUR_A:    begin op_base = m_r;  op_divisor = ri_r; end
      S_CUR_B:    begin op_base = n_r;  op_divisor = cj_r; end
      S_SRCH_DIV: begin
        op_base    = DB'(nt_r);
        op_divisor = srch_t_r;
        op_short   = 1'b1;
      end
      S_WR_A:     begin op_base = m_r;  op_divisor = nri_r; end
      S_WR_B:     begin op_base = n_r;  op_divisor = pcj_r; end
      S_WC_A:     begin op_base = n_r;  op_divisor = ncj_r; end
      S_WC_B:     begin op_base = m_r;  op_divisor = pri_r; end
      S_MU:       begin op_base = m_r;  op_divisor = row_panel_eff; op_ceil = 1'b1; end
      S_NU:       begin op_base = n_r;  op_divisor = col_panel_eff; op_ceil = 1'b1; end
      S_MOD:      begin op_base = nu_r; op_divisor = cj_r; end
      S_BEST_A:   begin op_base = mu_r; op_divisor = ri_r; op_ceil = 1'b1; end
      S_BEST_B:   begin op_base = nu_r; op_divisor = cj_r; op_ceil = 1'b1; end
      S_WK_A:     begin op_base = mu_r; op_divisor = cand_r_r; op_ceil = 1'b1; end
      S_WK_B:     begin op_base = nu_r; op_divisor = cand_c_r; op_ceil = 1'b1; end
      default:    div_state = 1'b0;
    endcase
  end

  assign ceil_add = op_ceil ? (DW'(op_divisor) - DW'(1)) : '0;

  always_comb begin
    div_req.start    = div_state && !wait_r && !((state_r == S_SRCH_DIV) && srch_term);
    div_req.short_op = op_short;
    div_req.divisor  = op_divisor;
    div_req.dividend = op_short ? DW'(nt_r) : (DW'(op_base) + ceil_add);
  end

  tgfa_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Second half of a two-division sum, taken when the divider reports done.
  assign sum      = acc_r + SW'(div_rsp.quot);
  assign done_go  = wait_r && div_rsp.done;
  assign orient_ok = ((m_r >= n_r) && (pri_r >= ncj_r)) ||
                     ((m_r <  n_r) && (pri_r <= ncj_r));

  // Configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_panel_r <= tgfa_pkg::ROW_PANEL_RST;
      col_panel_r <= tgfa_pkg::COL_PANEL_RST;
      panel_en_r  <= tgfa_pkg::PANEL_EN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tgfa_pkg::CFG_ROW_PANEL: row_panel_r <= cfg_data[tgfa_pkg::RPAN_W-1:0];
        tgfa_pkg::CFG_COL_PANEL: col_panel_r <= cfg_data[tgfa_pkg::CPAN_W-1:0];
        tgfa_pkg::CFG_PANEL_EN:  panel_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer. Each dividing state issues a division on entry, the search
  // state one per candidate; each waits for the divider and uses its result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A finished split loads the output register when it is empty or
      // being emptied in this same cycle.
      if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (div_req.start) begin
        wait_r <= 1'b1;
      end else if (done_go) begin
        wait_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            m_r     <= in_data.rows;
            n_r     <= in_data.cols;
            nt_r    <= tgfa_pkg::clamp_count(in_data.workers);
            ri_r    <= tgfa_pkg::clamp_count(in_data.row_ways_in);
            cj_r    <= tgfa_pkg::clamp_count(in_data.col_ways_in);
            state_r <= S_CUR_A;
          end
        end

        S_CUR_A: begin
          if (done_go) begin
            acc_r   <= div_rsp.quot;
            state_r <= S_CUR_B;
          end
        end
        S_CUR_B: begin
          if (done_go) begin
            cur_r      <= sum;
            srch_cur_r <= ri_r;
            srch_up_r  <= 1'b1;
            srch_ret_r <= S_NRI;
            state_r    <= S_SRCH_INIT;
          end
        end

        // Divisor search: next divisor above or previous below srch_cur_r.
        S_SRCH_INIT: begin
          if (srch_up_r) begin
            if (srch_cur_r == nt_r) begin
              srch_res_r <= srch_cur_r;
              state_r    <= srch_ret_r;
            end else begin
              srch_t_r <= srch_cur_r + WW'(1);
              state_r  <= S_SRCH_DIV;
            end
          end else begin
            if (srch_cur_r <= WW'(1)) begin
              srch_res_r <= WW'(1);
              state_r    <= srch_ret_r;
            end else begin
              srch_t_r <= srch_cur_r - WW'(1);
              state_r  <= S_SRCH_DIV;
            end
          end
        end
        S_SRCH_DIV: begin
          if (!wait_r && srch_term) begin
            srch_res_r <= srch_t_r;
            state_r    <= srch_ret_r;
          end else if (done_go) begin
            if (div_rsp.rem == '0) begin
              srch_res_r <= srch_t_r;
              state_r    <= srch_ret_r;
            end else begin
              srch_t_r <= srch_up_r ? (srch_t_r + WW'(1)) : (srch_t_r - WW'(1));
            end
          end
        end

        S_NRI: begin
          nri_r      <= srch_res_r;
          srch_cur_r <= ri_r;
          srch_up_r  <= 1'b0;
          srch_ret_r <= S_PRI;
          state_r    <= S_SRCH_INIT;
        end
        S_PRI: begin
          pri_r      <= srch_res_r;
          srch_cur_r <= cj_r;
          srch_up_r  <= 1'b1;
          srch_ret_r <= S_NCJ;
          state_r    <= S_SRCH_INIT;
        end
        S_NCJ: begin
          ncj_r      <= srch_res_r;
          srch_cur_r <= cj_r;
          srch_up_r  <= 1'b0;
          srch_ret_r <= S_PCJ;
          state_r    <= S_SRCH_INIT;
        end
        S_PCJ: begin
          pcj_r   <= srch_res_r;
          state_r <= S_WR_A;
        end

        // Raising the row ways wins on a tie; the column move is only
        // evaluated when the row move loses.
        S_WR_A: begin
          if (done_go) begin
            acc_r   <= div_rsp.quot;
            state_r <= S_WR_B;
          end
        end
        S_WR_B: begin
          if (done_go) begin
            if (sum <= cur_r) begin
              ri_r    <= nri_r;
              cj_r    <= pcj_r;
              state_r <= panel_en_r ? S_MU : S_DONE;
            end else begin
              state_r <= S_WC_A;
            end
          end
        end
        S_WC_A: begin
          if (done_go) begin
            acc_r   <= div_rsp.quot;
            state_r <= S_WC_B;
          end
        end
        S_WC_B: begin
          if (done_go) begin
            if ((sum < cur_r) && orient_ok) begin
              ri_r <= pri_r;
              cj_r <= ncj_r;
            end
            state_r <= panel_en_r ? S_MU : S_DONE;
          end
        end

        // Panel-balance stage.
        S_MU: begin
          if (done_go) begin
            mu_r    <= div_rsp.quot[DB-1:0];
            tri_r   <= ri_r;
            tcj_r   <= cj_r;
            step_r  <= 2'd0;
            state_r <= S_NU;
          end
        end
        S_NU: begin
          if (done_go) begin
            nu_r    <= div_rsp.quot[DB-1:0];
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (done_go) begin
            if ((div_rsp.rem != '0) && (tri_r < nt_r)) begin
              state_r <= (step_r == 2'd0) ? S_BEST_A : S_STEP;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_BEST_A: begin
          if (done_go) begin
            acc_r   <= div_rsp.quot;
            state_r <= S_BEST_B;
          end
        end
        S_BEST_B: begin
          if (done_go) begin
            best_r  <= sum;
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          srch_cur_r <= tri_r;
          srch_up_r  <= 1'b1;
          srch_ret_r <= S_CR;
          state_r    <= S_SRCH_INIT;
        end
        S_CR: begin
          cand_r_r   <= srch_res_r;
          srch_cur_r <= tcj_r;
          srch_up_r  <= 1'b0;
          srch_ret_r <= S_CC;
          state_r    <= S_SRCH_INIT;
        end
        S_CC: begin
          cand_c_r <= srch_res_r;
          state_r  <= S_WK_A;
        end
        S_WK_A: begin
          if (done_go) begin
            acc_r   <= div_rsp.quot;
            state_r <= S_WK_B;
          end
        end
        S_WK_B: begin
          if (done_go) begin
            if (sum < best_r) begin
              best_r <= sum;
              ri_r   <= cand_r_r;
              cj_r   <= cand_c_r;
            end
            tri_r <= cand_r_r;
            tcj_r <= cand_c_r;
            if (step_r == 2'd2) begin
              state_r <= S_DONE;
            end else begin
              step_r  <= step_r + 2'd1;
              state_r <= S_MOD;
            end
          end
        end

        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.row_ways_out <= ri_r;
            out_data_r.col_ways_out <= cj_r;
            state_r                 <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

>>> design/tgfa_serial_div.sv
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on tgfa_pkg for widths and the request/response structs.
// A short operation divides a WAY_W-bit value.
module tgfa_serial_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tgfa_pkg::div_req_t  req,
  output tgfa_pkg::div_rsp_t  rsp
);

  localparam int SHORT_SHIFT = tgfa_pkg::DIV_W - tgfa_pkg::WAY_W;

  logic [tgfa_pkg::DIV_W-1:0]  q_r;
  logic [tgfa_pkg::WAY_W-1:0]  dvs_r;
  logic [tgfa_pkg::WAY_W-1:0]  rem_r;
  logic [tgfa_pkg::DCNT_W-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [tgfa_pkg::WAY_W:0]    rem_sh;
  logic [tgfa_pkg::WAY_W+1:0]  diff;
  logic                        fits;
  logic [tgfa_pkg::WAY_W-1:0]  rem_nxt;

  assign rem_sh  = {rem_r, q_r[tgfa_pkg::DIV_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits    = ~diff[tgfa_pkg::WAY_W+1];
  assign rem_nxt = fits ? diff[tgfa_pkg::WAY_W-1:0] : rem_sh[tgfa_pkg::WAY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_op ? tgfa_pkg::DCNT_W'(tgfa_pkg::WAY_W)
                               : tgfa_pkg::DCNT_W'(tgfa_pkg::DIV_W);
        q_r    <= req.short_op ? (req.dividend << SHORT_SHIFT) : req.dividend;
        dvs_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        q_r   <= {q_r[tgfa_pkg::DIV_W-2:0], fits};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - tgfa_pkg::DCNT_W'(1);
        if (cnt_r == tgfa_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem  = rem_r;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for thread_grid_factor_adjust_unit: a split scoreboard
// class with its own predictor, tasks for the job and register channels
// and a result-side process. Depends on tgfa_pkg and the design files only.

// Scoreboard: keeps its own copy of the panel registers, predicts the
// adjusted split of every accepted job and checks results in order.
class split_scoreboard;
  typedef bit [tgfa_pkg::WAY_W-1:0] way_t;
  typedef bit [tgfa_pkg::DIV_W-1:0] quot_t;

  typedef struct {
    tgfa_pkg::in_item_t  job;
    tgfa_pkg::out_item_t split;
  } awaited_split_t;

  bit [tgfa_pkg::RPAN_W-1:0] row_panel;
  bit [tgfa_pkg::CPAN_W-1:0] col_panel;
  bit                        panel_en;
  awaited_split_t            awaited_splits[$];
  int                        mismatch_count;

  function new();
    row_panel      = tgfa_pkg::ROW_PANEL_RST;
    col_panel      = tgfa_pkg::COL_PANEL_RST;
    panel_en       = tgfa_pkg::PANEL_EN_RST;
    mismatch_count = 0;
  endfunction

  // Zero counts act as one; counts past the worker limit saturate.
  static function way_t limit_count(bit [tgfa_pkg::WAY_W-1:0] v);
    if (v == 0) return way_t'(1);
    if (v > tgfa_pkg::MAX_WORKERS) return way_t'(tgfa_pkg::MAX_WORKERS);
    return v;
  endfunction

  // Smallest divisor of total above from, or total itself when from equals
  // it; a count already past total just steps up by one.
  static function way_t next_divisor(way_t total, way_t from);
    way_t t;
    if (from == total) return from;
    t = from + way_t'(1);
    while (t <= total && total % t != 0) t++;
    return t;
  endfunction

  static function way_t prev_divisor(way_t total, way_t from);
    way_t t;
    if (from <= 1) return way_t'(1);
    t = from - way_t'(1);
    while (t >= 1 && total % t != 0) t--;
    return (t == 0) ? way_t'(1) : t;
  endfunction

  static function quot_t ceil_quot(quot_t a, quot_t b);
    return quot_t'((a + b - 1) / b);
  endfunction

  function void set_register(tgfa_pkg::cfg_reg_t idx, bit [tgfa_pkg::CFG_W-1:0] value);
    case (idx)
      tgfa_pkg::CFG_ROW_PANEL: row_panel = value[tgfa_pkg::RPAN_W-1:0];
      tgfa_pkg::CFG_COL_PANEL: col_panel = value[tgfa_pkg::CPAN_W-1:0];
      tgfa_pkg::CFG_PANEL_EN:  panel_en  = value[0];
      default: ;
    endcase
  endfunction

  function tgfa_pkg::out_item_t predict_split(tgfa_pkg::in_item_t job);
    bit [tgfa_pkg::DIM_BITS-1:0] m, n;
    way_t                        total, ri, cj, up_r, dn_r, up_c, dn_c;
    way_t                        try_r, try_c, cand_r, cand_c;
    bit [tgfa_pkg::SUM_W-1:0]    base, via_rows, via_cols;
    quot_t                       row_step, col_step, mu, nu, best, load;
    tgfa_pkg::out_item_t         split;
    m     = job.rows;
    n     = job.cols;
    total = limit_count(job.workers);
    ri    = limit_count(job.row_ways_in);
    cj    = limit_count(job.col_ways_in);

    // Stage one: move one divisor step along rows or along columns.
    base     = m / ri + n / cj;
    up_r     = next_divisor(total, ri);
    dn_r     = prev_divisor(total, ri);
    up_c     = next_divisor(total, cj);
    dn_c     = prev_divisor(total, cj);
    via_rows = m / up_r + n / dn_c;
    via_cols = n / up_c + m / dn_r;
    if (via_rows <= base) begin
      ri = up_r;
      cj = dn_c;
    end else if (via_cols < base &&
                 ((m >= n && dn_r >= up_c) || (m < n && dn_r <= up_c))) begin
      ri = dn_r;
      cj = up_c;
    end

    // Stage two: balance micro-panel counts with up to three row raises.
    if (panel_en) begin
      row_step = (row_panel == 0) ? quot_t'(1) : quot_t'(row_panel);
      col_step = (col_panel == 0) ? quot_t'(1) : quot_t'(col_panel);
      mu       = ceil_quot(m, row_step);
      nu       = ceil_quot(n, col_step);
      if (nu % cj != 0 && ri < total) begin
        best  = ceil_quot(mu, ri) + ceil_quot(nu, cj);
        try_r = ri;
        try_c = cj;
        for (int s = 0; s < 3; s++) begin
          if (s > 0 && !(nu % cj != 0 && try_r < total)) break;
          cand_r = next_divisor(total, try_r);
          cand_c = prev_divisor(total, try_c);
          load   = ceil_quot(mu, cand_r) + ceil_quot(nu, cand_c);
          if (load < best) begin
            best = load;
            ri   = cand_r;
            cj   = cand_c;
          end
          try_r = cand_r;
          try_c = cand_c;
        end
      end
    end

    split.row_ways_out = ri;
    split.col_ways_out = cj;
    return split;
  endfunction

  function void note_job(tgfa_pkg::in_item_t job);
    awaited_split_t a;
    a.job   = job;
    a.split = predict_split(job);
    awaited_splits.push_back(a);
  endfunction

  function int pending_count();
    return awaited_splits.size();
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task check_split(tgfa_pkg::out_item_t got);
    awaited_split_t want;
    string          job_text;
    if (awaited_splits.size() == 0) begin
      report_mismatch($sformatf("result %0d x %0d with no job outstanding",
                                got.row_ways_out, got.col_ways_out));
      return;
    end
    want     = awaited_splits.pop_front();
    job_text = $sformatf("m=%0d n=%0d w=%0d split %0dx%0d",
                         want.job.rows, want.job.cols, want.job.workers,
                         want.job.row_ways_in, want.job.col_ways_in);
    if (got.row_ways_out !== want.split.row_ways_out) begin
      report_mismatch($sformatf("%s: row ways %0d, want %0d", job_text,
                                got.row_ways_out, want.split.row_ways_out));
    end
    if (got.col_ways_out !== want.split.col_ways_out) begin
      report_mismatch($sformatf("%s: col ways %0d, want %0d", job_text,
                                got.col_ways_out, want.split.col_ways_out));
    end
  endtask
endclass

module testbench;

  localparam int WW = tgfa_pkg::WAY_W;
  localparam int CW = tgfa_pkg::CFG_W;
  localparam int DB = tgfa_pkg::DIM_BITS;

  // Register settings for the random phases. Phases past the table pick
  // their registers at random. The table covers the reset values, the
  // smallest panel sizes, a larger pair, zero sizes (taken as one), the
  // largest values the registers can hold, and the panel stage switched off.
  localparam int PHASES       = 8;
  localparam int PHASE_JOBS   = 86;
  localparam int TABLE_PHASES = 6;
  localparam int unsigned PHASE_ROW [TABLE_PHASES] = '{6, 1, 64, 6, 0, 127};
  localparam int unsigned PHASE_COL [TABLE_PHASES] = '{64, 1, 256, 64, 0, 511};
  localparam bit          PHASE_EN  [TABLE_PHASES] = '{1, 1, 1, 0, 1, 1};

  // Cycles allowed after the last result for a stray extra beat to show up.
  localparam int SETTLE_CYCLES = 1000;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  tgfa_pkg::in_item_t  in_data    = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  tgfa_pkg::out_item_t out_data;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [CW-1:0]       cfg_data  = '0;

  // Percentage of cycles in which the result side holds off.
  int hold_pct = 0;

  split_scoreboard sb;

  thread_grid_factor_adjust_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard ceiling on the run. A job whose worker count is a prime near the
  // limit tries nearly every candidate in its divisor searches, so this is
  // sized for every job taking as long as such a job, several times over.
  initial begin
    #(64'd2_000_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // Result side. All handshake signals are sampled right at the rising
  // edge, before any nonblocking update of that edge lands, so a beat is
  // taken exactly when the block sees valid and ready together. Ready is
  // redrawn every cycle from the current hold-off percentage.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_split(out_data);
    end
    out_ready <= ($urandom_range(0, 99) >= hold_pct);
  end

  function automatic tgfa_pkg::in_item_t make_job(bit [DB-1:0] rows,
                                                  bit [DB-1:0] cols,
                                                  bit [WW-1:0] workers,
                                                  bit [WW-1:0] row_ways,
                                                  bit [WW-1:0] col_ways);
    tgfa_pkg::in_item_t job;
    job.rows        = rows;
    job.cols        = cols;
    job.workers     = workers;
    job.row_ways_in = row_ways;
    job.col_ways_in = col_ways;
    return job;
  endfunction

  // Matrix sizes spread over every magnitude, with the all-ones value
  // showing up now and then.
  function automatic bit [DB-1:0] random_dim();
    int unsigned width;
    width = $urandom_range(0, DB);
    if ($urandom_range(0, 19) == 0) return '1;
    return DB'($urandom & ((32'd1 << width) - 1));
  endfunction

  // Writes all three panel registers back to back; valid stays high across
  // the three beats and drops once after the last one.
  task automatic program_panels(bit [CW-1:0] row_size,
                                bit [CW-1:0] col_size, bit enable);
    tgfa_pkg::cfg_reg_t order [3];
    bit [CW-1:0]        value [3];
    order = '{tgfa_pkg::CFG_ROW_PANEL, tgfa_pkg::CFG_COL_PANEL, tgfa_pkg::CFG_PANEL_EN};
    value = '{row_size, col_size, CW'(enable)};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[k];
      cfg_data  <= value[k];
      do @(posedge clk); while (!cfg_ready);
      sb.set_register(order[k], value[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Offers each job and holds it until the block takes the beat. Between
  // jobs the sender may go idle: short random gaps at the given rate, an
  // occasional long gap so idling lands on every stage of the block's
  // work, and now and then a full pause until every result is back.
  task automatic send_jobs(tgfa_pkg::in_item_t jobs[$], int idle_pct);
    int  gap;
    bit  pause;
    foreach (jobs[i]) begin
      in_valid <= 1'b1;
      in_data  <= jobs[i];
      do @(posedge clk); while (!in_ready);
      sb.note_job(jobs[i]);
      gap = 0;
      while ($urandom_range(0, 99) < idle_pct) gap++;
      if (idle_pct > 0 && $urandom_range(0, 15) == 0) begin
        gap += $urandom_range(1, 400);
      end
      pause = ($urandom_range(0, 59) == 0);
      if (gap > 0 || pause) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (pause) begin
          do @(posedge clk); while (sb.pending_count() != 0);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  initial begin
    tgfa_pkg::in_item_t jobs[$];
    tgfa_pkg::in_item_t job;
    int                 total, slot, ndiv, pick, idle_pct;
    bit [CW-1:0]        row_size, col_size;
    bit                 enable;

    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed jobs under the reset register values: empty and full-size
    // matrices, zero and saturating counts, way counts above the worker
    // count, splits that do not multiply out, a row-raise tie, tall and
    // wide matrices, prime and near-prime worker counts, and jobs where
    // the panel stage has room to move.
    jobs = {};
    jobs.push_back(make_job(0, 0, 1, 1, 1));
    jobs.push_back(make_job('1, '1, 256, 16, 16));
    jobs.push_back(make_job('1, 0, 256, 1, 256));
    jobs.push_back(make_job(0, '1, 256, 256, 1));
    jobs.push_back(make_job(0, 0, 0, 0, 0));
    jobs.push_back(make_job(1000, 1000, 511, 511, 511));
    jobs.push_back(make_job(5000, 300, 12, 0, 12));
    jobs.push_back(make_job(300, 5000, 12, 12, 0));
    jobs.push_back(make_job(777, 555, 6, 9, 1));
    jobs.push_back(make_job(12345, 678, 12, 5, 7));
    jobs.push_back(make_job(1000, 1000, 8, 2, 4));
    jobs.push_back(make_job(1000000, 10, 16, 4, 4));
    jobs.push_back(make_job(10, 1000000, 16, 4, 4));
    jobs.push_back(make_job(4096, 100, 251, 1, 251));
    jobs.push_back(make_job(100, 4096, 251, 251, 1));
    jobs.push_back(make_job(9999, 88888, 254, 2, 127));
    jobs.push_back(make_job(65, 130, 24, 4, 6));
    jobs.push_back(make_job(700, 9000, 64, 8, 8));
    jobs.push_back(make_job(24'h800000, 24'h7FFFFF, 384, 16, 24));
    jobs.push_back(make_job(3, 2, 2, 1, 2));
    send_jobs(jobs, 0);

    for (int p = 0; p < PHASES; p++) begin
      // Registers change only once every result of the previous phase is
      // back; each job yields exactly one result, so the block is idle.
      wait_drained();
      case (p % 4)
        0: begin
          idle_pct = 0;
          hold_pct <= 0;
        end
        1: begin
          idle_pct = 77;
          hold_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          hold_pct <= 77;
        end
        default: begin
          idle_pct = 36;
          hold_pct <= 36;
        end
      endcase
      if (p < TABLE_PHASES) begin
        row_size = CW'(PHASE_ROW[p]);
        col_size = CW'(PHASE_COL[p]);
        enable   = PHASE_EN[p];
      end else begin
        row_size = CW'($urandom_range(0, 511));
        col_size = CW'($urandom_range(0, 511));
        enable   = 1'($urandom_range(0, 1));
      end
      program_panels(row_size, col_size, enable);

      // Mostly well-formed jobs: the split is a true factorization of the
      // worker count. Most worker counts are small to keep the divisor
      // searches short; a few go up to the limit and past it. The rest are
      // malformed splits with arbitrary way counts.
      jobs = {};
      for (int k = 0; k < PHASE_JOBS; k++) begin
        job.rows = random_dim();
        job.cols = random_dim();
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          job.workers = WW'($urandom_range(1, 32));
        end else if (pick < 95) begin
          job.workers = WW'($urandom_range(33, tgfa_pkg::MAX_WORKERS));
        end else begin
          job.workers = WW'($urandom_range(0, 511));
        end
        total = int'(tgfa_pkg::clamp_count(job.workers));
        if ($urandom_range(0, 99) < 85) begin
          ndiv = 0;
          for (int d = 1; d <= total; d++) begin
            if (total % d == 0) ndiv++;
          end
          slot = $urandom_range(0, ndiv - 1);
          for (int d = 1; d <= total; d++) begin
            if (total % d == 0) begin
              if (slot == 0) job.row_ways_in = WW'(d);
              slot--;
            end
          end
          job.col_ways_in = WW'(total / int'(job.row_ways_in));
        end else if ($urandom_range(0, 1) == 0) begin
          job.row_ways_in = WW'($urandom_range(0, 40));
          job.col_ways_in = WW'($urandom_range(0, 40));
        end else begin
          job.row_ways_in = WW'($urandom_range(0, 511));
          job.col_ways_in = WW'($urandom_range(0, 511));
        end
        jobs.push_back(job);
      end
      send_jobs(jobs, idle_pct);
    end

    // Everything is sent: wait for the last results, then give a stray
    // extra beat time to appear before the verdict.
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
design/tgfa_pkg.sv
design/tgfa_serial_div.sv
design/thread_grid_factor_adjust_unit.sv
bench/testbench.sv
